>>> rtl/gmrdp_pkg.sv
// Package for the Gram matrix row dot products core.
// Holds the parameter defaults and the controller/datapath command and status types.
// No dependencies.
package gmrdp_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_DIM   = 64;
    localparam int DEF_ELEM_BITS = 16;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // store the element of an input transfer
        logic row_start;  // row complete: start with column 0, element 0
        logic issue;      // read one element pair into the MAC pipeline
        logic out_load;   // move the finished sum into the output register
        logic next_j;     // advance to the next column of the result row
        logic row_done;   // last result of the row loaded: move to the next row
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic col_last;   // load column is the last one of the row
        logic k_last;     // issue index is the last element of the row
        logic acc_done;   // accumulator holds a complete dot product
        logic j_is_i;     // current result column equals the result row
        logic out_free;   // output register can take a new result
    } t_dp_sts;

endpackage

>>> rtl/gmrdp_ctrl.sv
// Controller state machine of the Gram matrix row dot products core.
// Sequences loading, MAC issue and result hand-over; uses gmrdp_pkg.
module gmrdp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_cfg_wr,
    input  gmrdp_pkg::t_dp_sts i_sts,
    output logic               o_in_stall,
    output gmrdp_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_LOAD: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.col_last) begin
                        o_cmd.row_start = 1'b1;
                        n_state         = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (i_sts.k_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.acc_done && i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.j_is_i) begin
                        o_cmd.row_done = 1'b1;
                        n_state        = S_LOAD;
                    end else begin
                        o_cmd.next_j = 1'b1;
                        n_state      = S_ISSUE;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
        // a register write starts a new matrix
        if (i_cfg_wr) begin
            n_state = S_LOAD;
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/gmrdp_datapath.sv
// Datapath of the Gram matrix row dot products core: row store, position
// counters, dimension register, MAC pipeline and output register; uses gmrdp_pkg.
module gmrdp_datapath #(
    parameter int MAX_DIM   = gmrdp_pkg::DEF_MAX_DIM,
    parameter int ELEM_BITS = gmrdp_pkg::DEF_ELEM_BITS,
    parameter int IDX_BITS  = $clog2(MAX_DIM),
    parameter int CFG_BITS  = $clog2(MAX_DIM + 1),
    parameter int DOT_BITS  = 2 * ELEM_BITS + IDX_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gmrdp_pkg::t_dp_cmd   i_cmd,
    output gmrdp_pkg::t_dp_sts   o_sts,
    input  logic                 i_cfg_wr,
    input  logic [CFG_BITS-1:0]  i_cfg_data,
    input  logic [ELEM_BITS-1:0] i_element_value,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [IDX_BITS-1:0]  o_result_row,
    output logic [IDX_BITS-1:0]  o_result_col,
    output logic [DOT_BITS-1:0]  o_dot_value,
    output logic                 o_run_last
);

    localparam int ADDR_BITS = 2 * IDX_BITS;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;
    localparam int PROD_BITS = 2 * ELEM_BITS;

    logic [ELEM_BITS-1:0] r_mem [0:MEM_DEPTH-1];

    logic [IDX_BITS-1:0]  r_dim_last;
    logic [IDX_BITS-1:0]  r_load_row;
    logic [IDX_BITS-1:0]  r_load_col;
    logic [IDX_BITS-1:0]  r_j;
    logic [IDX_BITS-1:0]  r_k;
    logic                 r_v1, r_l1, r_v2, r_l2;
    logic [ELEM_BITS-1:0] r_rd_a, r_rd_b;
    logic [PROD_BITS-1:0] r_prod;
    logic [DOT_BITS-1:0]  r_acc;
    logic                 r_acc_done;
    logic [CFG_BITS-1:0]  w_cfg_m1;
    logic [IDX_BITS-1:0]  w_dim_last;

    // Dimension clamp: zero counts as one, above the store size as the store size
    assign w_cfg_m1 = i_cfg_data - CFG_BITS'(1);
    always_comb begin
        if (i_cfg_data == '0) begin
            w_dim_last = '0;
        end else if (i_cfg_data > CFG_BITS'(MAX_DIM)) begin
            w_dim_last = IDX_BITS'(MAX_DIM - 1);
        end else begin
            w_dim_last = w_cfg_m1[IDX_BITS-1:0];
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.col_last = (r_load_col == r_dim_last);
        o_sts.k_last   = (r_k == r_dim_last);
        o_sts.acc_done = r_acc_done;
        o_sts.j_is_i   = (r_j == r_load_row);
        o_sts.out_free = !o_out_valid || !i_out_stall;
    end

    // Row store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[{r_load_row, r_load_col}] <= i_element_value;
        end
        r_rd_a <= r_mem[{r_load_row, r_k}];
        r_rd_b <= r_mem[{r_j, r_k}];
    end

    // Product stage
    always_ff @(posedge i_clk) begin
        r_prod <= r_rd_a * r_rd_b;
    end

    // Control registers: dimension, positions, pipeline flags, accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_last <= IDX_BITS'(MAX_DIM - 1);
            r_load_row <= '0;
            r_load_col <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_v1       <= 1'b0;
            r_l1       <= 1'b0;
            r_v2       <= 1'b0;
            r_l2       <= 1'b0;
            r_acc      <= '0;
            r_acc_done <= 1'b0;
        end else if (i_cfg_wr) begin
            r_dim_last <= w_dim_last;
            r_load_row <= '0;
            r_load_col <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_acc      <= '0;
            r_acc_done <= 1'b0;
        end else begin
            // load position
            if (i_cmd.load) begin
                r_load_col <= o_sts.col_last ? '0 : r_load_col + IDX_BITS'(1);
            end
            if (i_cmd.row_done) begin
                r_load_row <= (r_load_row == r_dim_last) ? '0 : r_load_row + IDX_BITS'(1);
            end
            // column and element indices of the MAC sweep
            if (i_cmd.row_start) begin
                r_j <= '0;
                r_k <= '0;
            end else if (i_cmd.next_j) begin
                r_j <= r_j + IDX_BITS'(1);
                r_k <= '0;
            end else if (i_cmd.issue && !o_sts.k_last) begin
                r_k <= r_k + IDX_BITS'(1);
            end
            // pipeline flags follow the read and product stages
            r_v1 <= i_cmd.issue;
            r_l1 <= i_cmd.issue && o_sts.k_last;
            r_v2 <= r_v1;
            r_l2 <= r_l1;
            // accumulate stage
            if (i_cmd.out_load) begin
                r_acc      <= '0;
                r_acc_done <= 1'b0;
            end else if (r_v2) begin
                r_acc <= r_acc + {{(DOT_BITS - PROD_BITS){1'b0}}, r_prod};
                if (r_l2) begin
                    r_acc_done <= 1'b1;
                end
            end
        end
    end

    // Output register: valid under reset, payload without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_result_row <= r_load_row;
            o_result_col <= r_j;
            o_dot_value  <= r_acc;
            o_run_last   <= o_sts.j_is_i;
        end
    end

endmodule

>>> rtl/gram_matrix_row_dot_products_core.sv
// Gram matrix row dot products core: C[i][j] = row i . row j, j up to i.
// Pipeline: result (i, j) passes the read, product, accumulator and output
// registers; a row's first sweep starts the cycle after its last element
// transfer. Throughput: one element per cycle while loading; row i then takes
// one sweep of n pairs per column 0..i on the single MAC fed by the row store.
// Reset: synchronous, active low; positions cleared, n = MAX_DIM, row store kept.
module gram_matrix_row_dot_products_core #(
    parameter int MAX_DIM   = gmrdp_pkg::DEF_MAX_DIM,
    parameter int ELEM_BITS = gmrdp_pkg::DEF_ELEM_BITS,
    parameter int IDX_BITS  = $clog2(MAX_DIM),
    parameter int CFG_BITS  = $clog2(MAX_DIM + 1),
    parameter int DOT_BITS  = 2 * ELEM_BITS + IDX_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_BITS-1:0]  i_cfg_data,
    // element input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [ELEM_BITS-1:0] i_element_value,
    // result output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [IDX_BITS-1:0]  o_result_row,
    output logic [IDX_BITS-1:0]  o_result_col,
    output logic [DOT_BITS-1:0]  o_dot_value,
    output logic                 o_run_last
);

    gmrdp_pkg::t_dp_cmd w_cmd;
    gmrdp_pkg::t_dp_sts w_sts;
    logic               w_cfg_wr;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    gmrdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cfg_wr   (w_cfg_wr),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    gmrdp_datapath #(
        .MAX_DIM   (MAX_DIM),
        .ELEM_BITS (ELEM_BITS),
        .IDX_BITS  (IDX_BITS),
        .CFG_BITS  (CFG_BITS),
        .DOT_BITS  (DOT_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_wr        (w_cfg_wr),
        .i_cfg_data      (i_cfg_data),
        .i_element_value (i_element_value),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_result_row    (o_result_row),
        .o_result_col    (o_result_col),
        .o_dot_value     (o_dot_value),
        .o_run_last      (o_run_last)
    );

    // A result never overwrites one that is still held
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result loaded while output register is stalled");

    // Elements are only stored while no MAC sweep runs
    a_load_not_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> !w_cmd.issue && !w_sts.acc_done)
        else $error("element stored during a MAC sweep");

    // Results lie in the lower triangle
    a_lower_triangle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_result_col <= o_result_row)
        else $error("result column above result row");

    // The row's final result sits on the diagonal
    a_last_diagonal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_run_last) |-> o_result_col == o_result_row)
        else $error("last flag off the diagonal");

endmodule
